/* hw/rtl/swfn_pkg.sv */
// Shared types and constants for the sliding-window first-negative block.
// No dependencies; imported by every module under hw/rtl.
package swfn_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // window_size register
    localparam int              WS_W     = 7;
    localparam logic [WS_W-1:0] WS_RESET = 7'd1;

    // Register index, taken from the word-address bit of paddr
    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

    // Per-transaction queue commands from the window control to the queue
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_q_ctrl;

endpackage

/* hw/rtl/swfn_cfg.sv */
// APB-style configuration register (window_size) and effective window length.
// Depends on swfn_pkg.
module swfn_cfg #(
    parameter int  WINDOW_MAX = 64,
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swfn_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [swfn_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [swfn_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [CNT_W-1:0]                o_k,
    output logic                            o_clear
);
    import swfn_pkg::*;

    localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;

    logic [WS_W-1:0]  r_ws;
    logic [0:0]       reg_idx;
    logic             wr;
    logic             wr_ws;
    logic [CMP_W-1:0] ws_ext;
    logic [CMP_W-1:0] k_ext;

    assign reg_idx = paddr[CFG_ADDR_W-1];
    assign wr      = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb begin
        wr_ws  = 1'b0;
        prdata = '0;
        unique case (reg_idx)
            REG_WINDOW_SIZE: begin
                wr_ws  = wr;
                prdata = {{(CFG_DATA_W - WS_W){1'b0}}, r_ws};
            end
            default: begin
                wr_ws  = 1'b0;
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= WS_RESET;
        end else if (wr_ws) begin
            r_ws <= pwdata[WS_W-1:0];
        end
    end

    // Zero acts as one; clamp to the ring depth
    assign ws_ext = CMP_W'(r_ws);
    always_comb begin
        if (r_ws == '0) begin
            k_ext = CMP_W'(1);
        end else if (ws_ext > CMP_W'(WINDOW_MAX)) begin
            k_ext = CMP_W'(WINDOW_MAX);
        end else begin
            k_ext = ws_ext;
        end
    end

    assign o_k     = k_ext[CNT_W-1:0];
    assign o_clear = wr_ws;

endmodule

/* hw/rtl/swfn_queue.sv */
// FIFO of negative samples (value and ring position) with a registered head
// and a prefetched second entry. Depends on swfn_pkg.
module swfn_queue #(
    parameter int  WINDOW_MAX   = 64,
    parameter int  SAMPLE_WIDTH = 32,
    localparam int PTR_W        = $clog2(WINDOW_MAX),
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  swfn_pkg::t_q_ctrl       i_ctrl,
    input  logic [PTR_W-1:0]        i_push_pos,
    input  logic [SAMPLE_WIDTH-1:0] i_push_val,
    output logic [PTR_W-1:0]        o_front_pos,
    output logic [CNT_W-1:0]        o_cnt,
    output logic                    o_next_any,
    output logic [SAMPLE_WIDTH-1:0] o_next_val
);
    import swfn_pkg::*;

    localparam int ENT_W = PTR_W + SAMPLE_WIDTH;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW_MAX - 1);

    logic [ENT_W-1:0] mem [0:WINDOW_MAX-1];

    logic [PTR_W-1:0] r_hd, n_hd;
    logic [PTR_W-1:0] r_tl, n_tl;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ENT_W-1:0] r_front, n_front;
    logic [ENT_W-1:0] r_rd;
    logic [ENT_W-1:0] r_byp;
    logic             r_byp_hit;
    logic [CNT_W-1:0] cnt_pop;
    logic [ENT_W-1:0] push_ent;
    logic [ENT_W-1:0] second;
    logic [PTR_W-1:0] hd_wrap, tl_wrap, n_hd_wrap, rd_addr;

    assign push_ent = {i_push_pos, i_push_val};
    assign second   = r_byp_hit ? r_byp : r_rd;
    assign cnt_pop  = r_cnt - CNT_W'(i_ctrl.pop);

    assign hd_wrap = (r_hd == LAST_IDX) ? '0 : r_hd + PTR_W'(1);
    assign tl_wrap = (r_tl == LAST_IDX) ? '0 : r_tl + PTR_W'(1);

    always_comb begin
        if (i_ctrl.push && cnt_pop == '0) begin
            n_front = push_ent;
        end else if (i_ctrl.pop) begin
            n_front = second;
        end else begin
            n_front = r_front;
        end
        n_hd  = i_ctrl.pop  ? hd_wrap : r_hd;
        n_tl  = i_ctrl.push ? tl_wrap : r_tl;
        n_cnt = cnt_pop + CNT_W'(i_ctrl.push);
        if (i_ctrl.clear) begin
            n_hd  = '0;
            n_tl  = '0;
            n_cnt = '0;
        end
    end

    // Prefetch the entry behind the next head
    assign n_hd_wrap = (n_hd == LAST_IDX) ? '0 : n_hd + PTR_W'(1);
    assign rd_addr   = n_hd_wrap;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            mem[r_tl] <= push_ent;
        end
        r_rd      <= mem[rd_addr];
        r_byp     <= push_ent;
        r_byp_hit <= i_ctrl.push && (r_tl == rd_addr);
        r_front   <= n_front;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd  <= '0;
            r_tl  <= '0;
            r_cnt <= '0;
        end else begin
            r_hd  <= n_hd;
            r_tl  <= n_tl;
            r_cnt <= n_cnt;
        end
    end

    assign o_front_pos = r_front[ENT_W-1 -: PTR_W];
    assign o_cnt       = r_cnt;
    assign o_next_any  = (cnt_pop + CNT_W'(i_ctrl.push)) != '0;
    assign o_next_val  = n_front[SAMPLE_WIDTH-1:0];

endmodule

/* hw/rtl/swfn_outbuf.sv */
// Result register with a one-entry skid stage for the output channel.
// Depends on swfn_pkg.
module swfn_outbuf #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [SAMPLE_WIDTH-1:0] i_first_negative,
    input  logic                    i_has_negative,
    input  logic                    i_last_result,
    output logic                    o_full,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [SAMPLE_WIDTH-1:0] o_first_negative,
    output logic                    o_has_negative,
    output logic                    o_last_result
);
    import swfn_pkg::*;

    logic                    r_ov, r_sv;
    logic [SAMPLE_WIDTH-1:0] r_o_val, r_s_val;
    logic                    r_o_has, r_s_has;
    logic                    r_o_last, r_s_last;
    logic                    take;

    assign take = r_ov & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            // Skid full: input is held off, drain skid into output
            if (take) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_ov || take) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (take) begin
                r_o_val  <= r_s_val;
                r_o_has  <= r_s_has;
                r_o_last <= r_s_last;
            end
        end else if (i_push) begin
            if (!r_ov || take) begin
                r_o_val  <= i_first_negative;
                r_o_has  <= i_has_negative;
                r_o_last <= i_last_result;
            end else begin
                r_s_val  <= i_first_negative;
                r_s_has  <= i_has_negative;
                r_s_last <= i_last_result;
            end
        end
    end

    assign o_full           = r_sv;
    assign o_out_valid      = r_ov;
    assign o_first_negative = r_o_val;
    assign o_has_negative   = r_o_has;
    assign o_last_result    = r_o_last;

endmodule

/* hw/rtl/sliding_window_first_negative.sv */
// Sliding-window first-negative finder: top level with the window control.
// Depends on swfn_pkg, swfn_cfg, swfn_queue and swfn_outbuf.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one sample per transaction
//   with i_last_of_array marking the final sample of an array. For every full
//   window of window_size samples inside an array the output channel
//   (o_out_valid / i_out_stall) delivers one transaction: the oldest negative
//   sample in the window (o_first_negative, o_has_negative set) or zero with
//   o_has_negative clear. o_last_result marks the result of the array's final
//   window. Arrays shorter than the window produce no result.
//   A result enters the output register, or the skid stage while that is held,
//   as its sample is accepted. Throughput: one sample per cycle while o_in_stall
//   is low; the queue head is held in a register and the entry behind it is
//   prefetched from queue memory, so one push and one pop complete every cycle.
//   Reset: window_size returns to 1 and all pointers and counts clear; the
//   queue memory is not cleared, since no entry is read before it is written.
//   Writing window_size (APB, address 0) also starts a new array.
//   Receiver stall: the output register holds its transaction and one more
//   result lands in a skid stage; o_in_stall then rises until the skid drains.
module sliding_window_first_negative #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swfn_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [swfn_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [swfn_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    // Sample input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [SAMPLE_WIDTH-1:0]         i_sample,
    input  logic                            i_last_of_array,
    // Result output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [SAMPLE_WIDTH-1:0]         o_first_negative,
    output logic                            o_has_negative,
    output logic                            o_last_result
);
    import swfn_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int L_W   = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW_MAX - 1);

    logic [CNT_W-1:0]        k;
    logic                    cfg_clear;
    logic                    step;
    logic                    full_before;
    logic [L_W-1:0]          lv_sum;
    logic [PTR_W-1:0]        leaving;
    logic                    neg;
    logic                    pop;
    logic                    push;
    logic [CNT_W-1:0]        cnt_pop;
    t_q_ctrl                 q_ctrl;
    logic [PTR_W-1:0]        q_front_pos;
    logic [CNT_W-1:0]        q_cnt;
    logic                    q_next_any;
    logic [SAMPLE_WIDTH-1:0] q_next_val;
    logic [PTR_W-1:0]        r_rp, n_rp;
    logic [CNT_W-1:0]        r_seen, n_seen;
    logic                    produce;
    logic                    ob_full;

    swfn_cfg #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_k     (k),
        .o_clear (cfg_clear)
    );

    // Accept a sample whenever the skid stage is empty
    assign o_in_stall = ob_full;
    assign step       = i_in_valid & ~ob_full;

    // Ring slot of the sample that drops out of the window this step
    assign full_before = (r_seen >= k);
    assign lv_sum      = L_W'(r_rp) + L_W'(WINDOW_MAX) - L_W'(k);
    assign leaving     = (lv_sum >= L_W'(WINDOW_MAX)) ? PTR_W'(lv_sum - L_W'(WINDOW_MAX))
                                                      : PTR_W'(lv_sum);

    // Pop the head when it is the departing sample; push new negatives
    assign neg     = i_sample[SAMPLE_WIDTH-1];
    assign pop     = step & full_before & (q_cnt != '0) & (q_front_pos == leaving);
    assign cnt_pop = q_cnt - CNT_W'(pop);
    assign push    = step & neg & (cnt_pop < CNT_W'(WINDOW_MAX));

    assign q_ctrl.pop   = pop;
    assign q_ctrl.push  = push;
    assign q_ctrl.clear = cfg_clear | (step & i_last_of_array);

    swfn_queue #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (q_ctrl),
        .i_push_pos  (r_rp),
        .i_push_val  (i_sample),
        .o_front_pos (q_front_pos),
        .o_cnt       (q_cnt),
        .o_next_any  (q_next_any),
        .o_next_val  (q_next_val)
    );

    // Advance ring pointer and fill count; saturate the count at the window
    always_comb begin
        n_rp   = r_rp;
        n_seen = r_seen;
        if (step) begin
            n_rp   = (r_rp == LAST_IDX) ? '0 : r_rp + PTR_W'(1);
            n_seen = (r_seen < k) ? r_seen + CNT_W'(1) : r_seen;
        end
    end

    assign produce = step & (n_seen >= k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_seen <= '0;
        end else if (q_ctrl.clear) begin
            r_rp   <= '0;
            r_seen <= '0;
        end else begin
            r_rp   <= n_rp;
            r_seen <= n_seen;
        end
    end

    swfn_outbuf #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_outbuf (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (produce),
        .i_first_negative (q_next_any ? q_next_val : '0),
        .i_has_negative   (q_next_any),
        .i_last_result    (i_last_of_array),
        .o_full           (ob_full),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_first_negative (o_first_negative),
        .o_has_negative   (o_has_negative),
        .o_last_result    (o_last_result)
    );

endmodule

/* test/swfn_checker.sv */
// Checker for the sliding-window first-negative block: watches the APB writes and
// both the sample and result channels, predicts each window's result and compares it field by field.
// Depends on swfn_pkg for the register layout.
`timescale 1ns / 100ps

module swfn_checker #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [swfn_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [swfn_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [SAMPLE_WIDTH-1:0]         i_sample,
    input  logic                            i_last_of_array,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [SAMPLE_WIDTH-1:0]         i_first_negative,
    input  logic                            i_has_negative,
    input  logic                            i_last_result,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_with_negative
);

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] first_negative;
        logic                    has_negative;
        logic                    last_result;
    } t_window_result;

    logic [swfn_pkg::WS_W-1:0] window_reg;
    bit                        neg_flags  [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0]   neg_values [WINDOW_MAX];
    int                        neg_head, neg_tail, neg_count, ring_pos, fill;
    t_window_result            window_results [$];

    int error_count    = 0;
    int pending_count  = 0;
    int checked_count  = 0;
    int negative_count = 0;

    assign o_errors        = error_count;
    assign o_pending       = pending_count;
    assign o_checked       = checked_count;
    assign o_with_negative = negative_count;

    task automatic clear_array();
        neg_head  = 0;
        neg_tail  = 0;
        neg_count = 0;
        ring_pos  = 0;
        fill      = 0;
    endtask

    // Slide the window by one sample; queue the window's result once it is full.
    task automatic slide_window(input logic [SAMPLE_WIDTH-1:0] value, input bit last);
        int             k;
        int             leaving;
        bit             neg;
        t_window_result res;
        k   = (window_reg == 0) ? 1 : ((window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg);
        neg = value[SAMPLE_WIDTH-1];
        // drop the departing sample first
        if (fill >= k) begin
            leaving = (ring_pos + WINDOW_MAX - k) % WINDOW_MAX;
            if (neg_flags[leaving] && neg_count > 0) begin
                neg_head = (neg_head + 1) % WINDOW_MAX;
                neg_count--;
            end
        end
        neg_flags[ring_pos] = neg;
        if (neg && neg_count < WINDOW_MAX) begin
            neg_values[neg_tail] = value;
            neg_tail = (neg_tail + 1) % WINDOW_MAX;
            neg_count++;
        end
        ring_pos = (ring_pos + 1) % WINDOW_MAX;
        if (fill < k)
            fill++;
        if (fill >= k) begin
            res.has_negative   = (neg_count > 0);
            res.first_negative = res.has_negative ? neg_values[neg_head] : '0;
            res.last_result    = last;
            window_results.insert(window_results.size(), res);
        end
        if (last)
            clear_array();
    endtask

    always @(posedge i_clk) begin
        t_window_result want;
        if (!i_rst_n) begin
            window_reg = swfn_pkg::WS_RESET;
            clear_array();
            window_results.delete();
        end else begin
            // results first: a result never belongs to a sample taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                checked_count++;
                if (i_has_negative === 1'b1)
                    negative_count++;
                if (window_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, got first_negative %0d",
                             $time, $signed(i_first_negative));
                end else begin
                    want = window_results[0];
                    window_results.delete(0);
                    if (i_first_negative !== want.first_negative) begin
                        error_count++;
                        $display("%0t: first_negative: expected %0d, got %0d", $time,
                                 $signed(want.first_negative), $signed(i_first_negative));
                    end
                    if (i_has_negative !== want.has_negative) begin
                        error_count++;
                        $display("%0t: has_negative: expected %b, got %b", $time,
                                 want.has_negative, i_has_negative);
                    end
                    if (i_last_result !== want.last_result) begin
                        error_count++;
                        $display("%0t: last_result: expected %b, got %b", $time,
                                 want.last_result, i_last_result);
                    end
                end
            end
            if (psel && penable && pwrite && pready &&
                paddr[swfn_pkg::CFG_ADDR_W-1:2] == swfn_pkg::REG_WINDOW_SIZE) begin
                window_reg = pwdata[swfn_pkg::WS_W-1:0];
                clear_array();
            end
            if (i_in_valid && !i_in_stall)
                slide_window(i_sample, i_last_of_array);
        end
        pending_count = window_results.size();
    end

endmodule

/* test/sliding_window_first_negative_test.sv */
// Testbench top for the sliding-window first-negative block: clock, reset, APB writes,
// sample stimulus and receiver stalls; the verdict comes from swfn_checker.
// Depends on swfn_pkg, swfn_checker and the block under hw/rtl.
`timescale 1ns / 100ps

module sliding_window_first_negative_test;

    localparam int WINDOW_MAX    = 64;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_PCT      = 12;   // chance of an idle cycle on either side
    localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
    localparam int PHASE_SAMPLES = 190;
    localparam int SETTLE_CYCLES = 4;    // margin for the last sample to settle
    localparam int PHASE_COUNT   = 9;
    localparam int RUN_LIMIT_NS  = 400_000;

    // Word 1 of the register map is unmapped; writes to it must be dropped.
    localparam logic [0:0] REG_SPARE = 1'b1;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            psel            = 1'b0;
    logic                            penable         = 1'b0;
    logic                            pwrite          = 1'b0;
    logic [swfn_pkg::CFG_ADDR_W-1:0] paddr           = '0;
    logic [swfn_pkg::CFG_DATA_W-1:0] pwdata          = '0;
    logic [swfn_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            i_in_valid      = 1'b0;
    logic                            o_in_stall;
    logic [SAMPLE_WIDTH-1:0]         i_sample        = '0;
    logic                            i_last_of_array = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall     = 1'b0;
    logic [SAMPLE_WIDTH-1:0]         o_first_negative;
    logic                            o_has_negative;
    logic                            o_last_result;

    int error_count;
    int pending_windows;
    int windows_checked;
    int windows_negative;
    int samples_sent = 0;

    bit steady       = 1'b0;  // suppress random idling on both sides
    bit hold_request = 1'b0;  // ask the receiver for one long hold-off

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sliding_window_first_negative #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) dut (.*);

    swfn_checker #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .i_last_of_array (i_last_of_array),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_first_negative(o_first_negative),
        .i_has_negative  (o_has_negative),
        .i_last_result   (o_last_result),
        .o_errors        (error_count),
        .o_pending       (pending_windows),
        .o_checked       (windows_checked),
        .o_with_negative (windows_negative)
    );

    // Receiver: stall at random, or hold off for a long stretch on request so
    // the block backs up and stalls its input.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end
            i_out_stall = !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #RUN_LIMIT_NS;
        $display("status: fail");
        $finish;
    end

    // Offer one sample transaction and hold it until accepted. Called and
    // returns just after a falling edge; valid stays high for the next caller.
    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value, input bit last);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_sample        = value;
        i_last_of_array = last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        samples_sent++;
    endtask

    // Drop valid and wait until every predicted window result has come out.
    task automatic drain_windows();
        i_in_valid = 1'b0;
        while (pending_windows != 0)
            @(negedge i_clk);
    endtask

    // APB write, issued only once the block is idle: drain, then let the
    // last sample (which may produce no result) settle.
    task automatic write_reg(input logic [0:0] index, input logic [31:0] value);
        drain_windows();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Random sample with the requested chance of being negative; mix in the
    // sign-boundary values often.
    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample(input int neg_pct);
        logic [SAMPLE_WIDTH-1:0] v;
        bit                      neg;
        int                      shape;
        neg   = ($urandom_range(0, 99) < neg_pct);
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            v = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (shape == 1) begin
            v = neg ? 32'hFFFF_FFFF : 32'h0000_0000;
        end else begin
            v = $urandom;
            v[SAMPLE_WIDTH-1] = neg;
        end
        return v;
    endfunction

    initial begin
        // window sizes per phase: zero and oversize exercise the clamping
        logic [swfn_pkg::WS_W-1:0] settings [PHASE_COUNT] =
            '{7'd2, 7'd64, 7'd0, 7'd127, 7'd5, 7'd17, 7'd100, 7'd1, 7'd0};
        logic [swfn_pkg::WS_W-1:0] setting;
        logic [31:0]               word;
        int                        k, len, neg_pct, budget, arrays, pos;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: window of 1 straight out of reset, sign-boundary samples.
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);

        // Window of 3: the oldest negative leaves and the next one takes over;
        // an unmapped write in the middle must not disturb the array.
        write_reg(swfn_pkg::REG_WINDOW_SIZE, 32'd3);
        send_sample(-32'sd5, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(-32'sd9, 1'b0);
        write_reg(REG_SPARE, 32'h0000_0010);
        send_sample(32'sd4, 1'b0);
        send_sample(32'sd6, 1'b0);
        send_sample(32'sd8, 1'b1);

        // Array shorter than the window: no result, state still clears.
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd2, 1'b1);

        // Random phases, one window size each. A phase can stop mid-array, so
        // the next register write also covers a reconfiguration mid-array.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == PHASE_COUNT - 1)
                setting = swfn_pkg::WS_W'($urandom_range(1, WINDOW_MAX - 1));
            else
                setting = settings[phase];
            word = $urandom;
            word[swfn_pkg::WS_W-1:0] = setting;
            write_reg(swfn_pkg::REG_WINDOW_SIZE, word);
            k = (setting == 0) ? 1 : ((setting > WINDOW_MAX) ? WINDOW_MAX : setting);
            steady = (phase == 3);
            budget = PHASE_SAMPLES;
            arrays = 0;
            while (budget > 0) begin
                // mostly full arrays, some long enough to wrap the ring, a few short
                if (k > 1 && $urandom_range(0, 9) == 0)
                    len = $urandom_range(1, k - 1);
                else if ($urandom_range(0, 4) == 0)
                    len = k + $urandom_range(40, 120);
                else
                    len = k + $urandom_range(0, 24);
                case ($urandom_range(0, 4))
                    0:       neg_pct = 0;
                    1:       neg_pct = 3;
                    2:       neg_pct = 25;
                    3:       neg_pct = 60;
                    default: neg_pct = 100;
                endcase
                // pause the sender once until every result is out
                if (phase == 5 && arrays == 1)
                    drain_windows();
                for (pos = 0; pos < len && budget > 0; pos++) begin
                    // one long receiver hold-off while the sender keeps offering
                    if (phase == 1 && budget == PHASE_SAMPLES / 2)
                        hold_request = 1'b1;
                    send_sample(pick_sample(neg_pct), pos == len - 1);
                    budget--;
                end
                arrays++;
            end
        end
        steady = 1'b0;

        // Wait for the last results, then a settle margin for anything stray.
        drain_windows();
        repeat (2 * SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d samples over %0d window-size phases plus directed arrays",
                 samples_sent, PHASE_COUNT);
        $display("checked %0d window results, %0d of them with a negative sample",
                 windows_checked, windows_negative);
        if (error_count == 0 && pending_windows == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
